[rtl/core/rrts_pkg.sv]
package rrts_pkg;

    // fixed field widths
    localparam int ADDR_W = 32;
    localparam int SLOT_W = 4;
    localparam int REQ_W  = 2;

    // parameter defaults
    localparam int SLOTS_DEF     = 16;
    localparam int ADDR_BITS_DEF = 32;

    // request codes
    localparam logic [REQ_W-1:0] REQ_CREATE  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_YIELD   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DESTROY = 2'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR   = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [ADDR_W-1:0] entry_address;
        logic [ADDR_W-1:0] stack_address;
        logic [SLOT_W-1:0] target_slot;
    } req_t;

    typedef struct packed {
        logic              create_ok;
        logic [SLOT_W-1:0] created_slot;
        logic              current_valid;
        logic [SLOT_W-1:0] current_slot;
        logic [ADDR_W-1:0] current_entry;
        logic [ADDR_W-1:0] current_stack;
    } rsp_t;

    // scan unit control and status
    typedef struct packed {
        logic start;
        logic want_used;
    } scan_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic hit;
    } scan_stat_t;

endpackage

[rtl/core/rrts_ifs.sv]
interface rrts_req_if;
    logic          valid;
    logic          ready;
    rrts_pkg::req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface rrts_rsp_if;
    logic          valid;
    logic          ready;
    rrts_pkg::rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[rtl/core/rrts_scan.sv]
// round-robin slot scanner: probes one slot per cycle for a wanted used state
module rrts_scan #(
    parameter int SLOTS = rrts_pkg::SLOTS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  rrts_pkg::scan_ctl_t    ctl,
    input  logic [$clog2(SLOTS)-1:0] start_ptr,
    input  logic [SLOTS-1:0]       used,
    output rrts_pkg::scan_stat_t   stat,
    output logic [$clog2(SLOTS)-1:0] ptr
);

    localparam int IW = $clog2(SLOTS);

    logic          active_reg;
    logic          want_reg;
    logic [IW-1:0] ptr_reg;
    logic [IW-1:0] cnt_reg;
    logic          probe_hit;
    logic          probe_last;
    logic [IW-1:0] ptr_inc;

    assign probe_hit  = (used[ptr_reg] == want_reg);
    assign probe_last = (cnt_reg == IW'(SLOTS - 1));
    assign ptr_inc    = (ptr_reg == IW'(SLOTS - 1)) ? '0 : ptr_reg + IW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            want_reg   <= 1'b0;
            ptr_reg    <= '0;
            cnt_reg    <= '0;
        end
        else if (ctl.start)
        begin
            active_reg <= 1'b1;
            want_reg   <= ctl.want_used;
            ptr_reg    <= start_ptr;
            cnt_reg    <= '0;
        end
        else if (active_reg)
        begin
            if (probe_hit || probe_last)
            begin
                active_reg <= 1'b0;
            end
            else
            begin
                ptr_reg <= ptr_inc;
                cnt_reg <= cnt_reg + IW'(1);
            end
        end
    end

    assign stat.busy = active_reg;
    assign stat.done = active_reg && (probe_hit || probe_last);
    assign stat.hit  = active_reg && probe_hit;
    assign ptr       = ptr_reg;

endmodule

[rtl/core/rrts_mem.sv]
// slot address memory: one write port, one registered read port
module rrts_mem #(
    parameter int SLOTS = rrts_pkg::SLOTS_DEF,
    parameter int DW    = rrts_pkg::ADDR_W
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(SLOTS)-1:0] waddr,
    input  logic [DW-1:0]            wentry,
    input  logic [DW-1:0]            wstack,
    input  logic                     re,
    input  logic [$clog2(SLOTS)-1:0] raddr,
    output logic [DW-1:0]            rentry,
    output logic [DW-1:0]            rstack
);

    logic [2*DW-1:0] mem [SLOTS];
    logic [2*DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= {wentry, wstack};
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rentry = rdata_reg[2*DW-1:DW];
    assign rstack = rdata_reg[DW-1:0];

endmodule

[rtl/core/round_robin_thread_slot_table.sv]
// channel   dir   payload                                            handshake
// req       in    req_type, entry_address, stack_address, target_slot  valid/ready
// rsp       out   create_ok, created_slot, current_valid, current_slot,
//                 current_entry, current_stack                       valid/ready
//
// one request at a time; create, yield and destroy of the current slot run the
// shared scanner, which probes until it finds a match or has seen every slot;
// clear-all and destroy of a slot that is not current skip the scan; every
// request then passes the slot memory's read step and the output step
// the finished result sits in an output register, so the next request is
// taken while it waits; a stalled rsp holds the sequencer only at its last step
// asynchronous active-low reset frees all slots and clears the current pointer
module round_robin_thread_slot_table #(
    parameter int SLOTS     = rrts_pkg::SLOTS_DEF,
    parameter int ADDR_BITS = rrts_pkg::ADDR_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    rrts_req_if.sink   req,
    rrts_rsp_if.source rsp
);

    localparam int IW = $clog2(SLOTS);
    localparam int AW = rrts_pkg::ADDR_W;
    localparam int SW = rrts_pkg::SLOT_W;
    // stored address width: only the low result bits are ever reported
    localparam int DW = (ADDR_BITS < AW) ? ADDR_BITS : AW;

    // sequencer codes
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]                 state_reg, state_next;
    logic [SLOTS-1:0]           used_reg, used_next;
    logic [IW-1:0]              cur_reg, cur_next;
    logic                       present_reg, present_next;
    logic [rrts_pkg::REQ_W-1:0] req_type_reg;
    logic [DW-1:0]              entry_reg;
    logic [DW-1:0]              stack_reg;
    logic                       create_ok_reg, create_ok_next;
    logic [IW-1:0]              created_reg, created_next;
    logic                       rsp_valid_reg;
    rrts_pkg::rsp_t             rsp_reg;

    // scanner hookup
    rrts_pkg::scan_ctl_t        scan_ctl;
    rrts_pkg::scan_stat_t       scan_stat;
    logic [IW-1:0]              scan_start_ptr;
    logic [IW-1:0]              scan_ptr;

    // memory hookup
    logic                       mem_we;
    logic                       mem_re;
    logic [DW-1:0]              mem_entry;
    logic [DW-1:0]              mem_stack;

    logic                       accept;
    logic                       rsp_free;
    logic [IW-1:0]              cur_inc;
    logic [IW+SW-1:0]           target_ext;
    logic [IW-1:0]              target_idx;
    logic                       target_ok;
    logic [IW+SW-1:0]           cur_ext;
    logic [IW+SW-1:0]           created_ext;
    logic [DW+AW-1:0]           entry_ext;
    logic [DW+AW-1:0]           stack_ext;
    logic                       cur_live;

    assign accept   = req.valid && req.ready;
    assign rsp_free = !rsp_valid_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE);

    // slot after the current one, wrapping
    assign cur_inc = (cur_reg == IW'(SLOTS - 1)) ? '0 : cur_reg + IW'(1);

    // target slot resized to the index width, range checked against SLOTS
    assign target_ext = {{IW{1'b0}}, req.payload.target_slot};
    assign target_idx = target_ext[IW-1:0];
    assign target_ok  = ({{(AW-SW){1'b0}}, req.payload.target_slot} < AW'(SLOTS));

    rrts_scan #(
        .SLOTS (SLOTS)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (scan_ctl),
        .start_ptr (scan_start_ptr),
        .used      (used_reg),
        .stat      (scan_stat),
        .ptr       (scan_ptr)
    );

    rrts_mem #(
        .SLOTS (SLOTS),
        .DW    (DW)
    ) u_mem (
        .clk    (clk),
        .we     (mem_we),
        .waddr  (scan_ptr),
        .wentry (entry_reg),
        .wstack (stack_reg),
        .re     (mem_re),
        .raddr  (cur_reg),
        .rentry (mem_entry),
        .rstack (mem_stack)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        cur_next       = cur_reg;
        present_next   = present_reg;
        create_ok_next = create_ok_reg;
        created_next   = created_reg;
        scan_ctl       = '0;
        scan_start_ptr = cur_inc;
        mem_we         = 1'b0;
        mem_re         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    create_ok_next = 1'b0;
                    created_next   = '0;
                    state_next     = ST_READ;
                    unique case (req.payload.req_type)
                        rrts_pkg::REQ_CREATE:
                        begin
                            // lowest free slot
                            scan_ctl.start     = 1'b1;
                            scan_ctl.want_used = 1'b0;
                            scan_start_ptr     = '0;
                            state_next         = ST_SCAN;
                        end
                        rrts_pkg::REQ_YIELD:
                        begin
                            scan_ctl.start     = 1'b1;
                            scan_ctl.want_used = 1'b1;
                            state_next         = ST_SCAN;
                        end
                        rrts_pkg::REQ_DESTROY:
                        begin
                            if (target_ok)
                            begin
                                used_next[target_idx] = 1'b0;
                                // destroying the running thread moves on
                                if (present_reg && (cur_reg == target_idx))
                                begin
                                    scan_ctl.start     = 1'b1;
                                    scan_ctl.want_used = 1'b1;
                                    state_next         = ST_SCAN;
                                end
                            end
                        end
                        rrts_pkg::REQ_CLEAR:
                        begin
                            used_next = '0;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (scan_stat.done)
                begin
                    state_next = ST_READ;
                    if (req_type_reg == rrts_pkg::REQ_CREATE)
                    begin
                        if (scan_stat.hit)
                        begin
                            used_next[scan_ptr] = 1'b1;
                            mem_we              = 1'b1;
                            create_ok_next      = 1'b1;
                            created_next        = scan_ptr;
                            if (!present_reg)
                            begin
                                cur_next     = scan_ptr;
                                present_next = 1'b1;
                            end
                        end
                    end
                    else if (scan_stat.hit)
                    begin
                        cur_next     = scan_ptr;
                        present_next = 1'b1;
                    end
                    else
                    begin
                        // full lap without a used slot: index ends where it began
                        present_next = 1'b0;
                    end
                end
            end
            ST_READ:
            begin
                mem_re     = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            cur_reg       <= '0;
            present_reg   <= 1'b0;
            create_ok_reg <= 1'b0;
            created_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            cur_reg       <= cur_next;
            present_reg   <= present_next;
            create_ok_reg <= create_ok_next;
            created_reg   <= created_next;
            if ((state_reg == ST_OUT) && rsp_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // request payload, held for the scan and the memory write
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_type_reg <= req.payload.req_type;
            entry_reg    <= req.payload.entry_address[DW-1:0];
            stack_reg    <= req.payload.stack_address[DW-1:0];
        end
    end

    // result assembly; a freed slot reads as zero addresses
    assign cur_live    = present_reg && used_reg[cur_reg];
    assign cur_ext     = {{SW{1'b0}}, cur_reg};
    assign created_ext = {{SW{1'b0}}, created_reg};
    assign entry_ext   = {{AW{1'b0}}, mem_entry};
    assign stack_ext   = {{AW{1'b0}}, mem_stack};

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_OUT) && rsp_free)
        begin
            rsp_reg.create_ok     <= create_ok_reg;
            rsp_reg.created_slot  <= created_ext[SW-1:0];
            rsp_reg.current_valid <= present_reg;
            rsp_reg.current_slot  <= cur_ext[SW-1:0];
            rsp_reg.current_entry <= cur_live ? entry_ext[AW-1:0] : '0;
            rsp_reg.current_stack <= cur_live ? stack_ext[AW-1:0] : '0;
        end
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_reg;

    // checks

    // a new request never lands on a running scan
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !scan_stat.busy)
    else $error("request accepted while scanner busy");

    // a successful create marks its slot used
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SCAN) && scan_stat.done && scan_stat.hit &&
         (req_type_reg == rrts_pkg::REQ_CREATE)) |=> used_reg[$past(scan_ptr)])
    else $error("created slot not marked used");

    // a result is only raised from the last sequencer step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_OUT))
    else $error("result raised outside output step");

    // the current pointer stays inside the table
    assert property (@(posedge clk) disable iff (!rst_n)
        ({{(AW-IW){1'b0}}, cur_reg} < AW'(SLOTS)))
    else $error("current slot out of range");

endmodule

[tb/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS     = rrts_pkg::SLOTS_DEF;
    localparam int AW        = rrts_pkg::ADDR_W;
    localparam int SW        = rrts_pkg::SLOT_W;
    localparam int RW        = rrts_pkg::REQ_W;
    localparam int N_ITEMS   = 700;
    // long receiver hold-off, started once this many requests have gone in
    localparam int STALL_AT  = 180;
    localparam int STALL_LEN = 400;
    // the sender waits for every outstanding result before this request
    localparam int DRAIN_AT  = 420;
    // margin for the slowest request: the sequencer steps, a full scan of the slots, the memory read
    localparam int TAIL      = SLOTS + 8;
    localparam int LIMIT     = 200000;
    localparam logic [AW-1:0] ADDR_MASK = (rrts_pkg::ADDR_BITS_DEF >= AW) ?
        {AW{1'b1}} : ({AW{1'b1}} >> (AW - rrts_pkg::ADDR_BITS_DEF));

    // a request plus a flag telling the driver to drain the block first
    typedef struct {
        rrts_pkg::req_t body;
        bit             drain_first;
    } queued_req_t;

    logic clk;
    logic rst_n;

    rrts_req_if req_ch ();
    rrts_rsp_if rsp_ch ();

    round_robin_thread_slot_table uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // scheduler shadow state
    logic          thr_used  [SLOTS];
    logic [AW-1:0] thr_entry [SLOTS];
    logic [AW-1:0] thr_stack [SLOTS];
    int            cur_idx;
    logic          cur_live;

    queued_req_t    pending_q[$];
    rrts_pkg::rsp_t expected_q[$];

    int sent_cnt;
    int got_cnt;
    int mismatch_cnt;
    int total_items;
    int hold_left;
    int cycle_cnt;
    bit stall_done;

    // what the run exercised
    int n_create;
    int n_full;
    int n_yield;
    int n_destroy;
    int n_clear;
    int n_destroy_cur;

    // round-robin search from the slot after the current one
    function automatic void move_to_next_thread();
        cur_live = 1'b0;
        for (int n = 0; n < SLOTS; n++)
        begin
            cur_idx = (cur_idx + 1) % SLOTS;
            if (thr_used[cur_idx])
            begin
                cur_live = 1'b1;
                break;
            end
        end
    endfunction

    function automatic void free_thread(int s);
        thr_used[s]  = 1'b0;
        thr_entry[s] = '0;
        thr_stack[s] = '0;
    endfunction

    // apply one request to the shadow table and return the expected response
    function automatic rrts_pkg::rsp_t schedule_request(rrts_pkg::req_t r);
        rrts_pkg::rsp_t res;
        bit             placed;
        int             t;
        res    = '0;
        placed = 1'b0;
        case (r.req_type)
            rrts_pkg::REQ_CREATE:
            begin
                n_create++;
                // lowest free slot wins
                for (int s = 0; s < SLOTS; s++)
                begin
                    if (!thr_used[s] && !placed)
                    begin
                        placed           = 1'b1;
                        thr_used[s]      = 1'b1;
                        thr_entry[s]     = r.entry_address & ADDR_MASK;
                        thr_stack[s]     = r.stack_address & ADDR_MASK;
                        res.create_ok    = 1'b1;
                        res.created_slot = s[SW-1:0];
                        if (!cur_live)
                        begin
                            cur_idx  = s;
                            cur_live = 1'b1;
                        end
                    end
                end
                // table full: nothing changes, create_ok stays low
                if (!placed)
                    n_full++;
            end
            rrts_pkg::REQ_YIELD:
            begin
                n_yield++;
                move_to_next_thread();
            end
            rrts_pkg::REQ_DESTROY:
            begin
                n_destroy++;
                t = int'(r.target_slot);
                if (t < SLOTS)
                begin
                    free_thread(t);
                    // killing the running thread hands over to the next one
                    if (cur_live && cur_idx == t)
                    begin
                        n_destroy_cur++;
                        move_to_next_thread();
                    end
                end
            end
            default:
            begin
                // clear-all leaves the current pointer alone
                n_clear++;
                for (int s = 0; s < SLOTS; s++)
                    free_thread(s);
            end
        endcase
        res.current_valid = cur_live;
        res.current_slot  = cur_idx[SW-1:0];
        res.current_entry = cur_live ? thr_entry[cur_idx] : '0;
        res.current_stack = cur_live ? thr_stack[cur_idx] : '0;
        return res;
    endfunction

    task automatic queue_request(logic [RW-1:0] kind, logic [AW-1:0] entry,
                                 logic [AW-1:0] stack, logic [SW-1:0] target,
                                 bit drain);
        queued_req_t q;
        q.body.req_type      = kind;
        q.body.entry_address = entry;
        q.body.stack_address = stack;
        q.body.target_slot   = target;
        q.drain_first        = drain;
        pending_q.push_back(q);
    endtask

    task automatic report_mismatch(string msg);
        mismatch_cnt++;
        // keep the log short when things go badly wrong
        if (mismatch_cnt <= 30)
            $display("error: %s", msg);
    endtask

    task automatic compare_result(rrts_pkg::rsp_t got, rrts_pkg::rsp_t want, int n);
        if (got.create_ok !== want.create_ok)
            report_mismatch($sformatf("response %0d create_ok %0b, expected %0b",
                                      n, got.create_ok, want.create_ok));
        if (got.created_slot !== want.created_slot)
            report_mismatch($sformatf("response %0d created_slot %0d, expected %0d",
                                      n, got.created_slot, want.created_slot));
        if (got.current_valid !== want.current_valid)
            report_mismatch($sformatf("response %0d current_valid %0b, expected %0b",
                                      n, got.current_valid, want.current_valid));
        if (got.current_slot !== want.current_slot)
            report_mismatch($sformatf("response %0d current_slot %0d, expected %0d",
                                      n, got.current_slot, want.current_slot));
        if (got.current_entry !== want.current_entry)
            report_mismatch($sformatf("response %0d current_entry %h, expected %h",
                                      n, got.current_entry, want.current_entry));
        if (got.current_stack !== want.current_stack)
            report_mismatch($sformatf("response %0d current_stack %h, expected %h",
                                      n, got.current_stack, want.current_stack));
    endtask

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // request driver: offers the next pending request when the slot is free, subject to the idle mix and drain flag
    always @(posedge clk or negedge rst_n)
    begin
        int  send_idle;
        bit  drained;
        if (!rst_n)
        begin
            req_ch.valid   <= 1'b0;
            req_ch.payload <= '0;
        end
        else if (!req_ch.valid || req_ch.ready)
        begin
            // idle mix by thirds of the run: light, heavy, none
            case ((sent_cnt * 3) / total_items)
                0:       send_idle = 27;
                1:       send_idle = 49;
                default: send_idle = 0;
            endcase
            if (req_ch.valid)
            begin
                expected_q.push_back(schedule_request(req_ch.payload));
                sent_cnt <= sent_cnt + 1;
            end
            // block empty: nothing handed over now and every response back
            drained = !req_ch.valid && sent_cnt == got_cnt;
            if (pending_q.size() != 0 && (!pending_q[0].drain_first || drained) &&
                $urandom_range(99) >= send_idle)
            begin
                req_ch.payload <= pending_q[0].body;
                req_ch.valid   <= 1'b1;
                void'(pending_q.pop_front());
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // long receiver hold-off, counted here so the monitor only reads it
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left  <= 0;
            stall_done <= 1'b0;
        end
        else if (sent_cnt == STALL_AT && !stall_done)
        begin
            hold_left  <= STALL_LEN;
            stall_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // response monitor: checks against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        int recv_idle;
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            // receiver mix is the mirror image of the sender's
            case ((sent_cnt * 3) / total_items)
                0:       recv_idle = 49;
                1:       recv_idle = 27;
                default: recv_idle = 0;
            endcase
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_q.size() == 0)
                    report_mismatch($sformatf("response %0d arrived with no request waiting",
                                              got_cnt));
                else
                    compare_result(rsp_ch.payload, expected_q.pop_front(), got_cnt);
                got_cnt <= got_cnt + 1;
            end
            rsp_ch.ready <= hold_left == 0 && $urandom_range(99) >= recv_idle;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT)
        begin
            $display("timeout after %0d cycles, %0d of %0d responses seen",
                     cycle_cnt, got_cnt, total_items);
            $display("Mismatches found");
            $finish;
        end
    end

    // stimulus and end of run
    initial
    begin
        int            mode;
        int            pick;
        int            r_cnt;
        logic [RW-1:0] kind;

        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        rsp_ch.ready   = 1'b0;
        rst_n          = 1'b0;
        total_items    = 1;
        mode           = 0;
        r_cnt          = 0;

        // shadow table starts empty, like the block after reset
        for (int s = 0; s < SLOTS; s++)
            free_thread(s);
        cur_idx  = 0;
        cur_live = 1'b0;

        // yield on an empty table with no current thread
        queue_request(rrts_pkg::REQ_YIELD, $urandom, $urandom, SW'($urandom), 1'b0);
        // address extremes
        queue_request(rrts_pkg::REQ_CREATE, '0, '1, SW'($urandom), 1'b0);
        queue_request(rrts_pkg::REQ_CREATE, '1, '0, SW'($urandom), 1'b0);
        queue_request(rrts_pkg::REQ_YIELD, $urandom, $urandom, SW'($urandom), 1'b0);
        // destroy a slot that is not running, refill it
        queue_request(rrts_pkg::REQ_DESTROY, $urandom, $urandom, 4'd0, 1'b0);
        queue_request(rrts_pkg::REQ_CREATE, $urandom, $urandom, SW'($urandom), 1'b0);
        // destroy the running thread, hand-over to slot 0
        queue_request(rrts_pkg::REQ_DESTROY, $urandom, $urandom, 4'd1, 1'b0);
        // clear-all while running: pointer stays valid on a freed slot
        queue_request(rrts_pkg::REQ_CLEAR, $urandom, $urandom, SW'($urandom), 1'b0);
        // yield that finds nothing
        queue_request(rrts_pkg::REQ_YIELD, $urandom, $urandom, SW'($urandom), 1'b0);
        // fill every slot, then one create too many
        for (int i = 0; i <= SLOTS; i++)
            queue_request(rrts_pkg::REQ_CREATE, $urandom, $urandom, SW'($urandom), 1'b0);
        // top slot number
        queue_request(rrts_pkg::REQ_DESTROY, $urandom, $urandom, SW'(SLOTS - 1), 1'b0);

        // random part in segments that either fill or drain the table
        while (pending_q.size() < N_ITEMS)
        begin
            if (r_cnt % 40 == 0)
                mode = $urandom_range(1);
            pick = $urandom_range(99);
            if (mode == 1)
                kind = pick < 55 ? rrts_pkg::REQ_CREATE : pick < 80 ? rrts_pkg::REQ_YIELD :
                       pick < 97 ? rrts_pkg::REQ_DESTROY : rrts_pkg::REQ_CLEAR;
            else
                kind = pick < 25 ? rrts_pkg::REQ_CREATE : pick < 55 ? rrts_pkg::REQ_YIELD :
                       pick < 97 ? rrts_pkg::REQ_DESTROY : rrts_pkg::REQ_CLEAR;
            queue_request(kind, $urandom, $urandom, SW'($urandom_range(SLOTS - 1)),
                          pending_q.size() == DRAIN_AT);
            r_cnt++;
        end
        total_items = pending_q.size();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_q.size() == 0 && req_ch.valid === 1'b0);
        wait (got_cnt == sent_cnt);
        repeat (TAIL) @(posedge clk);
        if (expected_q.size() != 0)
            report_mismatch($sformatf("%0d responses never arrived", expected_q.size()));

        $display("%0d requests: %0d create (%0d on a full table), %0d yield, %0d destroy",
                 sent_cnt, n_create, n_full, n_yield, n_destroy);
        $display("%0d destroys hit the running thread, %0d clear-all, %0d responses checked",
                 n_destroy_cur, n_clear, got_cnt);
        if (mismatch_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[files.f]
rtl/core/rrts_pkg.sv
rtl/core/rrts_ifs.sv
rtl/core/rrts_scan.sv
rtl/core/rrts_mem.sv
rtl/core/round_robin_thread_slot_table.sv
tb/tb_top.sv
